FILE: rtl/ble_crc24_whitening_tx_unit_defines.svh
// ----------------------------------------------------------------------------
// ble_crc24_whitening_tx_unit_defines
// assertion macros shared by the transmit unit modules
// ----------------------------------------------------------------------------
`ifndef BLE_CRC24_WHITENING_TX_UNIT_DEFINES_SVH
`define BLE_CRC24_WHITENING_TX_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BLECRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BLECRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/blecrc_pkg.sv
// ----------------------------------------------------------------------------
// blecrc_pkg
// types, constants and bit-step functions for crc-24 and data whitening
// ----------------------------------------------------------------------------
package blecrc_pkg;

    localparam int CRC_W   = 24;
    localparam int LFSR_W  = 7;
    localparam int CHAN_W  = 6;
    localparam int BYTE_W  = 8;

    localparam logic [CRC_W-1:0]  CRC_PRESET   = 24'hAAAAAA;
    localparam logic [CRC_W-1:0]  CRC_FEEDBACK = 24'h5A6000;
    localparam logic [CHAN_W-1:0] CHAN_RESET   = 6'd37;

    typedef struct packed {
        logic [BYTE_W-1:0] pdu_byte;
        logic              last_in;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_out;
    } out_t;

    typedef struct packed {
        logic [LFSR_W-1:0] lfsr;
        logic [BYTE_W-1:0] data;
    } whiten_t;

    // result of one pdu byte, handed from core to output stage
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CRC_W-1:0]  crc;
        logic [LFSR_W-1:0] lfsr;
    } core_res_t;

    function automatic logic [LFSR_W-1:0] lfsr_seed(input logic [CHAN_W-1:0] chan);
        return {1'b1, chan};
    endfunction

    // eight crc bit steps, msb of the byte first
    function automatic logic [CRC_W-1:0] crc_fold8(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int n = BYTE_W - 1; n >= 0; n--)
        begin
            fb = c[0] ^ b[n];
            c  = {fb, c[CRC_W-1:1]};
            if (fb)
            begin
                c = c ^ CRC_FEEDBACK;
            end
        end
        return c;
    endfunction

    // eight whitening steps, lfsr x^7+x^4+1
    function automatic whiten_t whiten8(input logic [LFSR_W-1:0] lfsr_in,
                                        input logic [BYTE_W-1:0] b);
        whiten_t r;
        logic    w;
        r.lfsr = lfsr_in;
        r.data = b;
        for (int n = BYTE_W - 1; n >= 0; n--)
        begin
            w         = r.lfsr[0];
            r.data[n] = r.data[n] ^ w;
            r.lfsr    = {w, r.lfsr[LFSR_W-1:1]} ^ {4'b0000, w, 2'b00};
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] bit_rev8(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int n = 0; n < BYTE_W; n++)
        begin
            r[n] = b[BYTE_W-1-n];
        end
        return r;
    endfunction

endpackage

FILE: rtl/blecrc_core.sv
// ----------------------------------------------------------------------------
// blecrc_core
// crc and whitening state, folds and whitens one pdu byte per request
// ----------------------------------------------------------------------------
`include "ble_crc24_whitening_tx_unit_defines.svh"

module blecrc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [blecrc_pkg::CHAN_W-1:0]   cfg_wdata,
    input  logic                            take,
    input  blecrc_pkg::in_t                 in_data,
    output blecrc_pkg::core_res_t           res
);
    import blecrc_pkg::*;

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [CRC_W-1:0]  crc_fold;
    whiten_t           wres;
    logic              rearmed;

    assign crc_fold = crc_fold8(crc_reg, in_data.pdu_byte);
    assign wres     = whiten8(lfsr_reg, in_data.pdu_byte);

    // crc at its preset and lfsr carrying the seed's top bit
    assign rearmed  = (crc_reg == CRC_PRESET) && lfsr_reg[LFSR_W-1];

    always_comb
    begin
        res.data = wres.data;
        res.last = in_data.last_in;
        res.crc  = crc_fold;
        res.lfsr = wres.lfsr;
    end

    always_comb
    begin
        chan_next = chan_reg;
        crc_next  = crc_reg;
        lfsr_next = lfsr_reg;
        if (cfg_we)
        begin
            chan_next = cfg_wdata;
            crc_next  = CRC_PRESET;
            lfsr_next = lfsr_seed(cfg_wdata);
        end
        else if (take)
        begin
            if (in_data.last_in)
            begin
                // packet closed, re-arm for the next one
                crc_next  = CRC_PRESET;
                lfsr_next = lfsr_seed(chan_reg);
            end
            else
            begin
                crc_next  = crc_fold;
                lfsr_next = wres.lfsr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= CHAN_RESET;
            crc_reg  <= CRC_PRESET;
            lfsr_reg <= lfsr_seed(CHAN_RESET);
        end
        else
        begin
            chan_reg <= chan_next;
            crc_reg  <= crc_next;
            lfsr_reg <= lfsr_next;
        end
    end

    `BLECRC_ASSERT_NEXT(a_cfg_rearm, cfg_we, rearmed, "channel write did not re-arm")
    `BLECRC_ASSERT_NEXT(a_chan_write, cfg_we, chan_reg == $past(cfg_wdata), "channel missed")
    `BLECRC_ASSERT_NEXT(a_last_rearm, take && in_data.last_in && !cfg_we, rearmed, "no re-arm")

endmodule

FILE: rtl/blecrc_outq.sv
// ----------------------------------------------------------------------------
// blecrc_outq
// result register and crc tail sequencer, one byte per cycle to the output while out_ready is high
// ----------------------------------------------------------------------------
`include "ble_crc24_whitening_tx_unit_defines.svh"

module blecrc_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  blecrc_pkg::core_res_t   res,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output blecrc_pkg::out_t        out_data
);
    import blecrc_pkg::*;

    logic              valid_reg, valid_next;
    out_t              data_reg, data_next;
    logic [1:0]        tail_cnt_reg, tail_cnt_next;
    logic [CRC_W-1:0]  tail_crc_reg, tail_crc_next;
    logic [LFSR_W-1:0] tail_lfsr_reg, tail_lfsr_next;
    logic              drain;
    logic              tail_step;
    whiten_t           tail_w;

    assign drain     = valid_reg && out_ready;
    assign in_ready  = (!valid_reg || drain) && (tail_cnt_reg == 2'd0);
    assign take      = in_valid && in_ready;
    assign tail_step = drain && (tail_cnt_reg != 2'd0);
    assign tail_w    = whiten8(tail_lfsr_reg, bit_rev8(tail_crc_reg[BYTE_W-1:0]));

    always_comb
    begin
        valid_next     = valid_reg;
        data_next      = data_reg;
        tail_cnt_next  = tail_cnt_reg;
        tail_crc_next  = tail_crc_reg;
        tail_lfsr_next = tail_lfsr_reg;
        if (take)
        begin
            valid_next         = 1'b1;
            data_next.out_byte = res.data;
            data_next.last_out = 1'b0;
            if (res.last)
            begin
                tail_cnt_next  = 2'd3;
                tail_crc_next  = res.crc;
                tail_lfsr_next = res.lfsr;
            end
        end
        else if (tail_step)
        begin
            // crc bytes low, middle, high
            valid_next         = 1'b1;
            data_next.out_byte = tail_w.data;
            data_next.last_out = (tail_cnt_reg == 2'd1);
            tail_cnt_next      = tail_cnt_reg - 2'd1;
            tail_crc_next      = {8'h00, tail_crc_reg[CRC_W-1:BYTE_W]};
            tail_lfsr_next     = tail_w.lfsr;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            tail_cnt_reg <= 2'd0;
        end
        else
        begin
            valid_reg    <= valid_next;
            tail_cnt_reg <= tail_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        tail_crc_reg  <= tail_crc_next;
        tail_lfsr_reg <= tail_lfsr_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `BLECRC_ASSERT_NOW(a_tail_has_head, tail_cnt_reg != 2'd0, valid_reg, "crc tail pending with no byte in the result register")
    `BLECRC_ASSERT_NOW(a_last_ends_tail, valid_reg && data_reg.last_out, tail_cnt_reg == 2'd0, "packet end shown while crc bytes remain")
    `BLECRC_ASSERT_NEXT(a_tail_start, take && res.last, (tail_cnt_reg == 2'd3) && valid_reg, "last pdu byte did not start a three byte crc tail")

endmodule

FILE: rtl/ble_crc24_whitening_tx_unit.sv
// ----------------------------------------------------------------------------
// ble_crc24_whitening_tx_unit
// link-layer transmit engine: crc-24 over pdu bytes, whitening, crc append
// output: a request shows on the output in the cycle after it is taken
// throughput: one pdu byte per cycle while out_ready is high; a byte flagged last yields four
//   output bytes (its own byte plus three crc bytes from the tail sequencer)
// reset: channel 37, crc preset 0xaaaaaa, lfsr seeded 0x65, output empty
// ----------------------------------------------------------------------------
module ble_crc24_whitening_tx_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // channel register write, re-arms crc and lfsr
    input  logic                            cfg_we,
    input  logic [blecrc_pkg::CHAN_W-1:0]   cfg_wdata,
    // pdu byte requests
    input  logic                            in_valid,
    output logic                            in_ready,
    input  blecrc_pkg::in_t                 in_data,
    // whitened bytes for the air
    output logic                            out_valid,
    input  logic                            out_ready,
    output blecrc_pkg::out_t                out_data
);
    import blecrc_pkg::*;

    // take: a pdu request is accepted this cycle
    logic      take;
    // per-byte result: whitened byte, folded crc and lfsr after the byte
    core_res_t res;

    // state registers and the single-pass crc fold and whitening of one byte
    blecrc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .in_data   (in_data),
        .res       (res)
    );

    // result register; after a last byte it emits the three crc bytes,
    // holding off new requests until the last of them has been taken
    blecrc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res       (res),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
